### rtl/tfn_pkg.sv
// Shared types and fixed constants for the triangle face normal pipeline.
// No dependencies.
`default_nettype none

package tfn_pkg;

    localparam int NORM_BITS  = 30;   // magnitude width after normalization
    localparam int SQ_W       = 64;   // sum-of-squares / sqrt working width
    localparam int SQRT_STEPS = 32;   // one result bit per cell
    localparam int LEN_W      = 32;   // vector length width
    localparam int REM_W      = 33;   // divider remainder width (< 2 * length)
    localparam int OUT_W      = 16;   // output component width

    // sideband that travels with every beat through the chain
    typedef struct packed {
        logic       valid;
        logic       last;
        logic       degen;
        logic [2:0] neg;
    } tfn_side_t;

endpackage

`default_nettype wire

### rtl/tfn_norm_cell.sv
// One stage of the normalizing shifter: shifts all three magnitudes left by
// SHIFT when the top SHIFT bits of their OR are clear. Uses tfn_pkg.
`default_nettype none

module tfn_norm_cell
    import tfn_pkg::*;
#(
    parameter int W     = 50,
    parameter int SHIFT = 32
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [2:0][W-1:0]   mag_i,
    input  wire tfn_side_t           side_i,
    output logic      [2:0][W-1:0]   mag_o,
    output tfn_side_t                side_o
);

    logic [2:0][W-1:0] mag_reg, mag_next;
    tfn_side_t         side_reg;
    logic [W-1:0]      orw;

    always_comb
    begin
        orw = mag_i[0] | mag_i[1] | mag_i[2];
        if (orw[W-1 -: SHIFT] == '0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_next[i] = mag_i[i] << SHIFT;
            end
        end
        else
        begin
            mag_next = mag_i;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else
        begin
            side_reg <= side_i;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
    end

    assign mag_o  = mag_reg;
    assign side_o = side_reg;

endmodule

`default_nettype wire

### rtl/tfn_sqrt_cell.sv
// One digit step of the integer square root; carries the normalized
// magnitudes along for the divider. Uses tfn_pkg.
`default_nettype none

module tfn_sqrt_cell
    import tfn_pkg::*;
#(
    parameter int BIT_EXP = 62
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [SQ_W-1:0]               x_i,
    input  wire logic [SQ_W-1:0]               r_i,
    input  wire logic [2:0][NORM_BITS-1:0]     m_i,
    input  wire tfn_side_t                     side_i,
    output logic      [SQ_W-1:0]               x_o,
    output logic      [SQ_W-1:0]               r_o,
    output logic      [2:0][NORM_BITS-1:0]     m_o,
    output tfn_side_t                          side_o
);

    localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << BIT_EXP;

    logic [SQ_W-1:0]           x_reg, x_next;
    logic [SQ_W-1:0]           r_reg, r_next;
    logic [2:0][NORM_BITS-1:0] m_reg;
    tfn_side_t                 side_reg;
    logic [SQ_W-1:0]           trial;

    always_comb
    begin
        trial = r_i + BITV;
        if (x_i >= trial)
        begin
            x_next = x_i - trial;
            r_next = (r_i >> 1) + BITV;
        end
        else
        begin
            x_next = x_i;
            r_next = r_i >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else
        begin
            side_reg <= side_i;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        r_reg <= r_next;
        m_reg <= m_i;
    end

    assign x_o    = x_reg;
    assign r_o    = r_reg;
    assign m_o    = m_reg;
    assign side_o = side_reg;

endmodule

`default_nettype wire

### rtl/tfn_div_cell.sv
// One restoring-division step for all three normal components against the
// shared vector length. Uses tfn_pkg.
`default_nettype none

module tfn_div_cell
    import tfn_pkg::*;
#(
    parameter int QW = 15
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [LEN_W-1:0]          len_i,
    input  wire logic [2:0][REM_W-1:0]     rem_i,
    input  wire logic [2:0][QW-1:0]        num_i,
    input  wire logic [2:0][QW-1:0]        q_i,
    input  wire tfn_side_t                 side_i,
    output logic      [LEN_W-1:0]          len_o,
    output logic      [2:0][REM_W-1:0]     rem_o,
    output logic      [2:0][QW-1:0]        num_o,
    output logic      [2:0][QW-1:0]        q_o,
    output tfn_side_t                      side_o
);

    logic [LEN_W-1:0]      len_reg;
    logic [2:0][REM_W-1:0] rem_reg, rem_next;
    logic [2:0][QW-1:0]    num_reg, num_next;
    logic [2:0][QW-1:0]    q_reg, q_next;
    tfn_side_t             side_reg;
    logic [REM_W-1:0]      t;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t           = {rem_i[i][REM_W-2:0], num_i[i][QW-1]};
            num_next[i] = num_i[i] << 1;
            if (t >= {1'b0, len_i})
            begin
                rem_next[i] = t - {1'b0, len_i};
                q_next[i]   = {q_i[i][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = t;
                q_next[i]   = {q_i[i][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else
        begin
            side_reg <= side_i;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_i;
        rem_reg <= rem_next;
        num_reg <= num_next;
        q_reg   <= q_next;
    end

    assign len_o  = len_reg;
    assign rem_o  = rem_reg;
    assign num_o  = num_reg;
    assign q_o    = q_reg;
    assign side_o = side_reg;

endmodule

`default_nettype wire

### rtl/triangle_face_normal.sv
// Top level of the triangle face normal pipeline.
// Depends on tfn_pkg, tfn_norm_cell, tfn_sqrt_cell and tfn_div_cell.
//
// Usage:
//   Input beat: one triangle (vertices a, b, c in signed Q12.12 and the
//   last_in mark) is taken at every rising edge with start high and busy
//   low. busy is always low: the pipeline never stalls, so a new triangle
//   may be offered every clock.
//   Result beat: nx/ny/nz (signed, NORMAL_FRAC_BITS fraction bits),
//   degenerate and last_out are on the ports for exactly one cycle with
//   done high. The receiver cannot stall; results must be taken as shown.
//   Throughput: one triangle per clock.
//   Chain: edge subtract, products, cross, magnitude, a row of shift cells
//   that normalize to 30 bits, squares, sum, 32 square-root digit cells,
//   divider setup, NORMAL_FRAC_BITS+1 divider cells, output stage.
//   Reset: rst_n clears every valid bit at once; no beats are in flight
//   afterward and the block takes a triangle on the first edge after it.
`default_nettype none

module triangle_face_normal
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH      = 24,
    parameter int NORMAL_FRAC_BITS = 14
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] ax,
    input  wire logic signed [COORD_WIDTH-1:0] ay,
    input  wire logic signed [COORD_WIDTH-1:0] az,
    input  wire logic signed [COORD_WIDTH-1:0] bx,
    input  wire logic signed [COORD_WIDTH-1:0] by,
    input  wire logic signed [COORD_WIDTH-1:0] bz,
    input  wire logic signed [COORD_WIDTH-1:0] cx,
    input  wire logic signed [COORD_WIDTH-1:0] cy,
    input  wire logic signed [COORD_WIDTH-1:0] cz,
    input  wire logic                          last_in,
    output logic                               done,
    output logic signed [OUT_W-1:0]            nx,
    output logic signed [OUT_W-1:0]            ny,
    output logic signed [OUT_W-1:0]            nz,
    output logic                               degenerate,
    output logic                               last_out
);

    localparam int CW  = COORD_WIDTH;
    localparam int F   = NORMAL_FRAC_BITS;
    localparam int ES  = (CW > 30) ? CW - 30 : 0;     // edge pre-shift
    localparam int EW  = CW + 1 - ES;                  // edge width
    localparam int MW  = 2 * EW;                       // cross magnitude width
    localparam int AW  = (MW < NORM_BITS) ? NORM_BITS : MW;
    localparam int SS  = $clog2(AW);                   // shift cells
    localparam int QW  = F + 1;                        // quotient bits
    localparam int NW  = NORM_BITS + F + 1;            // dividend width
    localparam int LAT = SS + F + 42;

    // ---------------- edges ----------------
    logic signed [CW-1:0] a_v [3];
    logic signed [CW-1:0] b_v [3];
    logic signed [CW-1:0] c_v [3];
    logic signed [CW:0]   d1 [3];
    logic signed [CW:0]   d2 [3];
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [EW-1:0] e1_next [3];
    logic signed [EW-1:0] e2_next [3];
    tfn_side_t            s1_reg, s1_next;

    assign a_v[0] = ax;
    assign a_v[1] = ay;
    assign a_v[2] = az;
    assign b_v[0] = bx;
    assign b_v[1] = by;
    assign b_v[2] = bz;
    assign c_v[0] = cx;
    assign c_v[1] = cy;
    assign c_v[2] = cz;

    assign busy = 1'b0;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1[i]      = (CW+1)'(a_v[i]) - (CW+1)'(b_v[i]);
            d2[i]      = (CW+1)'(c_v[i]) - (CW+1)'(b_v[i]);
            // arithmetic shift is a floor shift
            e1_next[i] = EW'(d1[i] >>> ES);
            e2_next[i] = EW'(d2[i] >>> ES);
        end
        s1_next       = '0;
        s1_next.valid = start && !busy;
        s1_next.last  = last_in;
    end

    // ---------------- products and cross ----------------
    logic signed [MW-1:0] p_reg [6];
    logic signed [MW-1:0] p_next [6];
    tfn_side_t            s2_reg;
    logic signed [MW:0]   cr_reg [3];
    logic signed [MW:0]   cr_next [3];
    tfn_side_t            s3_reg;

    always_comb
    begin
        p_next[0] = e1_reg[1] * e2_reg[2];
        p_next[1] = e1_reg[2] * e2_reg[1];
        p_next[2] = e1_reg[2] * e2_reg[0];
        p_next[3] = e1_reg[0] * e2_reg[2];
        p_next[4] = e1_reg[0] * e2_reg[1];
        p_next[5] = e1_reg[1] * e2_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            cr_next[i] = (MW+1)'(p_reg[2*i]) - (MW+1)'(p_reg[2*i+1]);
        end
    end

    // ---------------- magnitude, sign, degenerate ----------------
    logic [2:0][AW-1:0] mag_reg, mag_next;
    tfn_side_t          s4_reg, s4_next;
    logic [MW:0]        absv;

    always_comb
    begin
        s4_next = s3_reg;
        for (int i = 0; i < 3; i++)
        begin
            s4_next.neg[i] = cr_reg[i][MW];
            absv           = cr_reg[i][MW] ? -cr_reg[i] : cr_reg[i];
            mag_next[i]    = AW'(absv[MW-1:0]);
        end
        s4_next.degen = (cr_reg[0] == '0) && (cr_reg[1] == '0) && (cr_reg[2] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            s4_reg <= s4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_reg  <= e1_next;
        e2_reg  <= e2_next;
        p_reg   <= p_next;
        cr_reg  <= cr_next;
        mag_reg <= mag_next;
    end

    // ---------------- normalizing shift chain ----------------
    logic [2:0][AW-1:0] nm [SS+1];
    tfn_side_t          ns [SS+1];

    assign nm[0] = mag_reg;
    assign ns[0] = s4_reg;

    for (genvar k = 0; k < SS; k++)
    begin : g_norm
        tfn_norm_cell #(
            .W     (AW),
            .SHIFT (1 << (SS - 1 - k))
        ) u_norm (
            .clk    (clk),
            .rst_n  (rst_n),
            .mag_i  (nm[k]),
            .side_i (ns[k]),
            .mag_o  (nm[k+1]),
            .side_o (ns[k+1])
        );
    end

    // ---------------- squares and sum ----------------
    logic [2:0][NORM_BITS-1:0]   m_reg, m_next, m2_reg, m3_reg;
    logic [2:0][2*NORM_BITS-1:0] sq_reg, sq_next;
    logic [SQ_W-1:0]             x_reg, x_next;
    tfn_side_t                   s5_reg, s6_reg, s6b_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // top bits of the left-aligned word: exact left or truncating right
            m_next[i]  = nm[SS][i][AW-1 -: NORM_BITS];
            sq_next[i] = m_reg[i] * m_reg[i];
        end
        x_next = SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_reg  <= '0;
            s6_reg  <= '0;
            s6b_reg <= '0;
        end
        else
        begin
            s5_reg  <= ns[SS];
            s6_reg  <= s5_reg;
            s6b_reg <= s6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg  <= m_next;
        sq_reg <= sq_next;
        m2_reg <= m_reg;
        m3_reg <= m2_reg;
        x_reg  <= x_next;
    end

    // ---------------- square root chain ----------------
    logic [SQ_W-1:0]           sx [SQRT_STEPS+1];
    logic [SQ_W-1:0]           sr [SQRT_STEPS+1];
    logic [2:0][NORM_BITS-1:0] sm [SQRT_STEPS+1];
    tfn_side_t                 sside [SQRT_STEPS+1];

    // sum stage: magnitudes and sideband pass through one more register (m3_reg, s6b_reg) to stay aligned
    assign sx[0]    = x_reg;
    assign sr[0]    = '0;
    assign sm[0]    = m3_reg;
    assign sside[0] = s6b_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        tfn_sqrt_cell #(
            .BIT_EXP (2 * (SQRT_STEPS - 1 - k))
        ) u_sqrt (
            .clk    (clk),
            .rst_n  (rst_n),
            .x_i    (sx[k]),
            .r_i    (sr[k]),
            .m_i    (sm[k]),
            .side_i (sside[k]),
            .x_o    (sx[k+1]),
            .r_o    (sr[k+1]),
            .m_o    (sm[k+1]),
            .side_o (sside[k+1])
        );
    end

    // ---------------- divider setup ----------------
    logic [LEN_W-1:0]      len_v;
    logic [NW-1:0]         nn;
    logic [LEN_W-1:0]      dl0_reg;
    logic [2:0][REM_W-1:0] dr0_reg, dr0_next;
    logic [2:0][QW-1:0]    dn0_reg, dn0_next;
    tfn_side_t             s7_reg;

    always_comb
    begin
        len_v = sr[SQRT_STEPS][LEN_W-1:0];
        nn    = '0;
        for (int i = 0; i < 3; i++)
        begin
            // m * 2^F + L/2, rounds half up
            nn          = (NW'(sm[SQRT_STEPS][i]) << F) + NW'(len_v >> 1);
            dr0_next[i] = REM_W'(nn >> QW);
            dn0_next[i] = nn[QW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_reg <= '0;
        end
        else
        begin
            s7_reg <= sside[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        dl0_reg <= len_v;
        dr0_reg <= dr0_next;
        dn0_reg <= dn0_next;
    end

    // ---------------- divider chain ----------------
    logic [LEN_W-1:0]      dl [QW+1];
    logic [2:0][REM_W-1:0] dr [QW+1];
    logic [2:0][QW-1:0]    dn [QW+1];
    logic [2:0][QW-1:0]    dq [QW+1];
    tfn_side_t             dside [QW+1];

    assign dl[0]    = dl0_reg;
    assign dr[0]    = dr0_reg;
    assign dn[0]    = dn0_reg;
    assign dq[0]    = '0;
    assign dside[0] = s7_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        tfn_div_cell #(
            .QW (QW)
        ) u_div (
            .clk    (clk),
            .rst_n  (rst_n),
            .len_i  (dl[k]),
            .rem_i  (dr[k]),
            .num_i  (dn[k]),
            .q_i    (dq[k]),
            .side_i (dside[k]),
            .len_o  (dl[k+1]),
            .rem_o  (dr[k+1]),
            .num_o  (dn[k+1]),
            .q_o    (dq[k+1]),
            .side_o (dside[k+1])
        );
    end

    // ---------------- output stage ----------------
    logic [2:0][OUT_W-1:0] n_reg, n_next;
    tfn_side_t             so_reg;
    logic [31:0]           sv;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sv = dside[QW].neg[i] ? (32'd0 - 32'(dq[QW][i])) : 32'(dq[QW][i]);
            n_next[i] = dside[QW].degen ? '0 : sv[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            so_reg <= '0;
        end
        else
        begin
            so_reg <= dside[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
    end

    assign done       = so_reg.valid;
    assign nx         = n_reg[0];
    assign ny         = n_reg[1];
    assign nz         = n_reg[2];
    assign degenerate = so_reg.degen;
    assign last_out   = so_reg.last;

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(start && !busy && rst_n, LAT))
        else $error("result strobe out of step with accepted triangles");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (nx == '0 && ny == '0 && nz == '0))
        else $error("degenerate triangle with nonzero normal");

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dside[QW].valid && !dside[QW].degen) |->
        (dq[QW][0] <= (QW'(1) << F) && dq[QW][1] <= (QW'(1) << F)
         && dq[QW][2] <= (QW'(1) << F)))
        else $error("normal component above unit length");

    a_norm_msb: assert property (@(posedge clk) disable iff (!rst_n)
        (s5_reg.valid && !s5_reg.degen) |->
        (m_reg[0][NORM_BITS-1] || m_reg[1][NORM_BITS-1] || m_reg[2][NORM_BITS-1]))
        else $error("normalization left top bit clear");

endmodule

`default_nettype wire
